FILE: rtl/sphere_collision_pushout_core_macros.svh
// assertion macros for the sphere pushout block
`ifndef SPHERE_COLLISION_PUSHOUT_CORE_MACROS_SVH
`define SPHERE_COLLISION_PUSHOUT_CORE_MACROS_SVH

// same-cycle implication, sampled on clk, off during rst
`define SPHPO_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sphpo assertion failed");

// next-cycle implication, sampled on clk, off during rst
`define SPHPO_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sphpo assertion failed");

`endif

FILE: rtl/sphpo_pkg.sv
package sphpo_pkg;

  localparam int MAX_COLLIDERS = 16;
  localparam int IDX_W = 4;
  localparam int CNT_W = 5;
  localparam int SQRT_STEPS = 33;
  localparam int DIV_STEPS = 66;

  localparam logic [1:0] FUNC_LOAD    = 2'd0;
  localparam logic [1:0] FUNC_QUERY   = 2'd1;
  localparam logic [1:0] FUNC_RESTART = 2'd2;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic [30:0]        radius;
  } entry_t;

  typedef enum logic {
    DS_SQRT,
    DS_DIV
  } ds_mode_t;

  typedef struct packed {
    logic     start;
    ds_mode_t mode;
  } ds_req_t;

  typedef struct packed {
    logic        done;
    logic [33:0] res;
  } ds_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MX,
    ST_MY,
    ST_MZ,
    ST_MR,
    ST_CMP,
    ST_SQRT_GO,
    ST_SQRT_WAIT,
    ST_AX_MUL,
    ST_AX_LOAD,
    ST_DIV_WAIT,
    ST_FINISH
  } state_t;

endpackage

FILE: rtl/sphpo_table.sv
module sphpo_table #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // storage, no reset
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/sphpo_mul.sv
module sphpo_mul
  import sphpo_pkg::*;
(
  input  logic        clk,
  input  logic [32:0] a,
  input  logic [32:0] b,
  output logic [65:0] prod
);

  // shared registered multiplier
  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule

FILE: rtl/sphpo_divsqrt.sv
module sphpo_divsqrt
  import sphpo_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  ds_req_t     req,
  input  logic [65:0] num,
  input  logic [33:0] den,
  output ds_rsp_t     rsp
);

  logic        busy;
  ds_mode_t    mode;
  logic [65:0] work;
  logic [37:0] rem;
  logic [33:0] res;
  logic [33:0] den_r;
  logic [6:0]  cnt;
  logic        done;

  logic [37:0] shifted;
  logic [37:0] trial;
  logic        ge;

  // one shift, compare and subtract step
  always_comb begin
    if (mode == DS_SQRT) begin
      shifted = {rem[35:0], work[65:64]};
      trial   = {2'b00, res, 2'b01};
    end else begin
      shifted = {rem[36:0], work[65]};
      trial   = {4'b0000, den_r};
    end
    ge = (shifted >= trial);
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= (req.mode == DS_SQRT) ? 7'(SQRT_STEPS) : 7'(DIV_STEPS);
      end else if (busy) begin
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      mode  <= req.mode;
      work  <= num;
      den_r <= den;
      rem   <= '0;
      res   <= '0;
    end else if (busy) begin
      rem  <= ge ? (shifted - trial) : shifted;
      res  <= {res[32:0], ge};
      work <= (mode == DS_SQRT) ? {work[63:0], 2'b00} : {work[64:0], 1'b0};
    end
  end

  assign rsp.done = done;
  assign rsp.res  = res;

endmodule

FILE: rtl/sphere_collision_pushout_core.sv
// load and restart beats do not make the block busy; a query scans the
// colliders in turn (scan, three squares, radius square, compare) until one is
// hit, then a square root and three divides on the shared shift-subtract unit.
// throughput: one query at a time; the input is stalled until it finishes.
// reset: rst is synchronous, clears cursor, count and handshake state;
// collider table is not cleared and must be loaded before use.
module sphere_collision_pushout_core
  import sphpo_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wen,
  input  logic [CNT_W-1:0]    cfg_wdata,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          func,
  input  logic [IDX_W-1:0]    entry_index,
  input  logic signed [31:0]  pos_x,
  input  logic signed [31:0]  pos_y,
  input  logic signed [31:0]  pos_z,
  input  logic [30:0]         sphere_radius,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                hit,
  output logic [IDX_W-1:0]    hit_index,
  output logic signed [31:0]  push_x,
  output logic signed [31:0]  push_y,
  output logic signed [31:0]  push_z
);

  state_t state, state_next;

  logic [CNT_W-1:0] collider_count;
  logic [CNT_W-1:0] cursor;
  logic [CNT_W-1:0] cursor_next;
  logic [CNT_W-1:0] limit;

  logic signed [31:0] qx, qy, qz;
  logic [30:0]        qrad;
  logic signed [32:0] dx, dy, dz;
  logic [31:0]        rsum;
  logic [65:0]        acc;
  logic [33:0]        len;
  logic [1:0]         axis;
  logic               hit_r;
  logic signed [31:0] wpx, wpy, wpz;

  logic        in_acc;
  logic        out_free;
  entry_t      ent;
  entry_t      wentry;
  logic [32:0] mul_a, mul_b;
  logic [65:0] prod;
  ds_req_t     ds_req;
  ds_rsp_t     ds_rsp;
  logic [65:0] ds_num;

  logic signed [32:0] d_axis;
  logic [32:0]        mag_axis;
  logic signed [31:0] c_axis;
  logic signed [33:0] off;
  logic signed [33:0] sum;
  logic signed [31:0] sat;

  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != ST_IDLE);
  assign limit    = (collider_count > CNT_W'(MAX_COLLIDERS)) ?
                    CNT_W'(MAX_COLLIDERS) : collider_count;

  function automatic logic [32:0] mag33(logic signed [32:0] v);
    return v[32] ? 33'(-v) : 33'(v);
  endfunction

  // collider table
  assign wentry.x      = pos_x;
  assign wentry.y      = pos_y;
  assign wentry.z      = pos_z;
  assign wentry.radius = sphere_radius;

  // read address follows the next cursor so the registered entry matches cursor
  sphpo_table #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (MAX_COLLIDERS)
  ) u_table (
    .clk   (clk),
    .we    (in_acc && func == FUNC_LOAD),
    .waddr (entry_index),
    .wdata (wentry),
    .raddr (cursor_next[IDX_W-1:0]),
    .rdata (ent)
  );

  // shared multiplier
  sphpo_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  // shared root and divide unit
  assign ds_num = (state == ST_SQRT_GO) ? acc : {1'b0, prod[64:0]};

  sphpo_divsqrt u_ds (
    .clk (clk),
    .rst (rst),
    .req (ds_req),
    .num (ds_num),
    .den (len),
    .rsp (ds_rsp)
  );

  // current axis operands and saturated push value
  always_comb begin
    case (axis)
      2'd0:    begin d_axis = dx; c_axis = ent.x; end
      2'd1:    begin d_axis = dy; c_axis = ent.y; end
      default: begin d_axis = dz; c_axis = ent.z; end
    endcase
    mag_axis = mag33(d_axis);
    off = {1'b0, ds_rsp.res[32:0]};
    sum = 34'(c_axis) + (d_axis[32] ? -off : off);
    if (sum > 34'sd2147483647) begin
      sat = 32'sh7fffffff;
    end else if (sum < -34'sd2147483648) begin
      sat = 32'sh80000000;
    end else begin
      sat = sum[31:0];
    end
  end

  // sequencer next state and unit controls
  always_comb begin
    state_next    = state;
    mul_a         = '0;
    mul_b         = '0;
    ds_req.start  = 1'b0;
    ds_req.mode   = DS_SQRT;
    case (state)
      ST_IDLE: begin
        if (in_acc && func == FUNC_QUERY) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        state_next = (cursor < limit) ? ST_MX : ST_FINISH;
      end
      ST_MX: begin
        mul_a = mag33(dx);
        mul_b = mag33(dx);
        state_next = ST_MY;
      end
      ST_MY: begin
        mul_a = mag33(dy);
        mul_b = mag33(dy);
        state_next = ST_MZ;
      end
      ST_MZ: begin
        mul_a = mag33(dz);
        mul_b = mag33(dz);
        state_next = ST_MR;
      end
      ST_MR: begin
        mul_a = {1'b0, rsum};
        mul_b = {1'b0, rsum};
        state_next = ST_CMP;
      end
      ST_CMP: begin
        state_next = (acc <= prod) ? ST_SQRT_GO : ST_SCAN;
      end
      ST_SQRT_GO: begin
        ds_req.start = 1'b1;
        ds_req.mode  = DS_SQRT;
        state_next   = ST_SQRT_WAIT;
      end
      ST_SQRT_WAIT: begin
        if (ds_rsp.done) begin
          state_next = (ds_rsp.res == '0) ? ST_FINISH : ST_AX_MUL;
        end
      end
      ST_AX_MUL: begin
        mul_a = mag_axis;
        mul_b = {1'b0, rsum};
        state_next = ST_AX_LOAD;
      end
      ST_AX_LOAD: begin
        ds_req.start = 1'b1;
        ds_req.mode  = DS_DIV;
        state_next   = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (ds_rsp.done) begin
          state_next = (axis == 2'd2) ? ST_FINISH : ST_AX_MUL;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next scan cursor
  always_comb begin
    cursor_next = cursor;
    if (in_acc && func == FUNC_RESTART) begin
      cursor_next = '0;
    end else if (state == ST_CMP && !(acc <= prod)) begin
      cursor_next = cursor + CNT_W'(1);
    end
  end

  // count register and scan cursor
  always_ff @(posedge clk) begin
    if (rst) begin
      collider_count <= '0;
      cursor         <= '0;
    end else begin
      if (cfg_wen) begin
        collider_count <= cfg_wdata;
      end
      cursor <= cursor_next;
    end
  end

  // query datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        qx    <= pos_x;
        qy    <= pos_y;
        qz    <= pos_z;
        qrad  <= sphere_radius;
        hit_r <= 1'b0;
        wpx   <= '0;
        wpy   <= '0;
        wpz   <= '0;
      end
      ST_SCAN: begin
        dx   <= 33'(qx) - 33'(ent.x);
        dy   <= 33'(qy) - 33'(ent.y);
        dz   <= 33'(qz) - 33'(ent.z);
        rsum <= 32'(qrad) + 32'(ent.radius);
      end
      ST_MY:   acc <= prod;
      ST_MZ:   acc <= acc + prod;
      ST_MR:   acc <= acc + prod;
      ST_CMP: begin
        if (acc <= prod) begin
          hit_r <= 1'b1;
        end
      end
      ST_SQRT_WAIT: begin
        axis <= 2'd0;
        if (ds_rsp.done) begin
          len <= ds_rsp.res;
          wpx <= ent.x;
          wpy <= ent.y;
          wpz <= ent.z;
        end
      end
      ST_DIV_WAIT: begin
        if (ds_rsp.done) begin
          case (axis)
            2'd0:    wpx <= sat;
            2'd1:    wpy <= sat;
            default: wpz <= sat;
          endcase
          axis <= axis + 2'd1;
        end
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_FINISH && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FINISH && out_free) begin
      hit       <= hit_r;
      hit_index <= hit_r ? cursor[IDX_W-1:0] : '0;
      push_x    <= wpx;
      push_y    <= wpy;
      push_z    <= wpz;
    end
  end

endmodule

FILE: rtl/sphpo_checker.sv
`include "sphere_collision_pushout_core_macros.svh"

module sphpo_checker
  import sphpo_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic [1:0]         func,
  input logic               out_valid,
  input logic               out_stall,
  input logic               hit,
  input logic [IDX_W-1:0]   hit_index,
  input logic signed [31:0] push_x,
  input logic signed [31:0] push_y,
  input logic signed [31:0] push_z
);

  // stalled result beat holds
  `SPHPO_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(hit) && $stable(push_x))

  // a miss carries an all-zero payload
  `SPHPO_ASSERT_NOW(a_miss_zero, out_valid && !hit, hit_index == '0 && push_x == 0 && push_y == 0 && push_z == 0)

  // a query beat makes the block busy
  `SPHPO_ASSERT_NEXT(a_query_busy, in_valid && !in_stall && func == FUNC_QUERY, in_stall)

  // other beats leave it ready
  `SPHPO_ASSERT_NEXT(a_other_ready, in_valid && !in_stall && func != FUNC_QUERY, !in_stall)

endmodule

bind sphere_collision_pushout_core sphpo_checker u_sphpo_checker (.*);
